### hdl/totp_pkg.sv
package totp_pkg;

  localparam int KeyWords = 8;
  localparam int CodeLen  = 5;
  localparam int CfgIdxW  = 3;

  localparam logic [31:0] ShaH0 = 32'h67452301;
  localparam logic [31:0] ShaH1 = 32'hEFCDAB89;
  localparam logic [31:0] ShaH2 = 32'h98BADCFE;
  localparam logic [31:0] ShaH3 = 32'h10325476;
  localparam logic [31:0] ShaH4 = 32'hC3D2E1F0;

  localparam logic [31:0] ShaK0 = 32'h5A827999;
  localparam logic [31:0] ShaK1 = 32'h6ED9EBA1;
  localparam logic [31:0] ShaK2 = 32'h8F1BBCDC;
  localparam logic [31:0] ShaK3 = 32'hCA62C1D6;

  localparam logic [31:0] IpadWord = 32'h36363636;
  localparam logic [31:0] OpadWord = 32'h5C5C5C5C;
  localparam logic [31:0] PadOne   = 32'h80000000;
  localparam logic [31:0] InnerLen = 32'd576;
  localparam logic [31:0] OuterLen = 32'd672;

  // divider: time slice and base-26 digit divisors, with reciprocals of the
  // halved divisors, ceil(2^24 / 15) and ceil(2^24 / 13)
  localparam logic [4:0]  DivSlice   = 5'd30;
  localparam logic [4:0]  DivDigit   = 5'd26;
  localparam logic [20:0] RecipSlice = 21'd1118482;
  localparam logic [20:0] RecipDigit = 21'd1290556;

  typedef logic [159:0] digest_t;
  typedef logic [511:0] block_t;

  // sha core control
  typedef struct packed {
    logic   start;
    logic   fresh;   // chain from init vector instead of previous digest
  } sha_ctl_t;

  typedef struct packed {
    logic    busy;
    logic    done;
  } sha_sts_t;

  function automatic logic [6:0] alpha_char(input logic [4:0] d);
    logic [6:0] c;
    case (d)
      5'd0:  c = 7'h32;  5'd1:  c = 7'h33;  5'd2:  c = 7'h34;  5'd3:  c = 7'h35;
      5'd4:  c = 7'h36;  5'd5:  c = 7'h37;  5'd6:  c = 7'h38;  5'd7:  c = 7'h39;
      5'd8:  c = 7'h42;  5'd9:  c = 7'h43;  5'd10: c = 7'h44;  5'd11: c = 7'h46;
      5'd12: c = 7'h47;  5'd13: c = 7'h48;  5'd14: c = 7'h4A;  5'd15: c = 7'h4B;
      5'd16: c = 7'h4D;  5'd17: c = 7'h4E;  5'd18: c = 7'h50;  5'd19: c = 7'h51;
      5'd20: c = 7'h52;  5'd21: c = 7'h54;  5'd22: c = 7'h56;  5'd23: c = 7'h57;
      5'd24: c = 7'h58;  5'd25: c = 7'h59;
      default: c = 7'h32;
    endcase
    return c;
  endfunction

endpackage

### hdl/totp_sha1_core.sv
module totp_sha1_core (
  input  logic              clk,
  input  logic              rst,
  input  totp_pkg::sha_ctl_t ctl,
  input  totp_pkg::block_t   blk,
  output totp_pkg::sha_sts_t sts,
  output totp_pkg::digest_t  digest
);
  import totp_pkg::*;

  logic [31:0] w [16];
  logic [31:0] a, b, c, d, e;
  logic [31:0] h [5];
  logic [6:0]  rnd;
  logic        busy;
  logic        done;

  logic [31:0] f, k, t, wnew, wcur;
  logic [31:0] hin [5];

  always_comb begin
    if (rnd < 7'd20) begin
      f = (b & c) | (~b & d);
      k = ShaK0;
    end else if (rnd < 7'd40) begin
      f = b ^ c ^ d;
      k = ShaK1;
    end else if (rnd < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
      k = ShaK2;
    end else begin
      f = b ^ c ^ d;
      k = ShaK3;
    end
    wcur = w[0];
    t    = {a[26:0], a[31:27]} + f + e + k + wcur;
    wnew = w[13] ^ w[8] ^ w[2] ^ w[0];
    wnew = {wnew[30:0], wnew[31]};
  end

  always_comb begin
    if (ctl.fresh) begin
      hin[0] = ShaH0; hin[1] = ShaH1; hin[2] = ShaH2; hin[3] = ShaH3; hin[4] = ShaH4;
    end else begin
      for (int i = 0; i < 5; i++) hin[i] = h[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      rnd  <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start && !busy) begin
        busy <= 1'b1;
        rnd  <= '0;
        for (int i = 0; i < 5; i++) h[i] <= hin[i];
        a <= hin[0]; b <= hin[1]; c <= hin[2]; d <= hin[3]; e <= hin[4];
        for (int i = 0; i < 16; i++) w[i] <= blk[511 - 32*i -: 32];
      end else if (busy) begin
        if (rnd == 7'd80) begin
          h[0] <= h[0] + a; h[1] <= h[1] + b; h[2] <= h[2] + c;
          h[3] <= h[3] + d; h[4] <= h[4] + e;
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          e <= d; d <= c; c <= {b[1:0], b[31:2]}; b <= a; a <= t;
          for (int i = 0; i < 15; i++) w[i] <= w[i+1];
          w[15] <= wnew;
          rnd <= rnd + 7'd1;
        end
      end
    end
  end

  assign sts.busy = busy;
  assign sts.done = done;
  assign digest   = {h[0], h[1], h[2], h[3], h[4]};

`ifndef SYNTHESIS
  a_rnd_range: assert property (@(posedge clk) disable iff (rst) rnd <= 7'd80)
    else $error("round count overrun");
  a_done_end: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy) && !busy) else $error("done without round end");
  a_start_clr: assert property (@(posedge clk) disable iff (rst)
    (ctl.start && !busy) |=> busy && rnd == 7'd0) else $error("start missed");
`endif

endmodule

### hdl/totp_div_unit.sv
module totp_div_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        digit,   // high: divide by 26, low: divide by 30
  input  logic [63:0] num,
  output logic        done,
  output logic [63:0] quo,
  output logic [4:0]  rem
);
  import totp_pkg::*;

  // long division in 16-bit chunks, one chunk per cycle; the chunk quotient
  // is a reciprocal multiply of the halved partial remainder
  logic [4:0]  den;
  logic [20:0] recip;
  logic [20:0] part;     // {remainder, chunk}, below den * 2^16
  logic [40:0] prod;
  logic [15:0] qd;
  logic [20:0] back;
  logic [20:0] diff;
  logic [4:0]  r;
  logic [1:0]  cnt;
  logic        busy;
  logic        sel;

  assign den   = sel ? DivDigit : DivSlice;
  assign recip = sel ? RecipDigit : RecipSlice;
  assign part  = {r, quo[63:48]};
  assign prod  = part[20:1] * recip;
  assign qd    = prod[39:24];
  assign back  = {5'd0, qd} * {16'd0, den};
  assign diff  = part - back;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
      r    <= '0;
      sel  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        sel  <= digit;
        quo  <= num;
        r    <= '0;
        cnt  <= '0;
      end else if (busy) begin
        quo <= {quo[47:0], qd};
        r   <= diff[4:0];
        cnt <= cnt + 2'd1;
        if (cnt == 2'd3) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rem = r;

`ifndef SYNTHESIS
  a_cnt: assert property (@(posedge clk) disable iff (rst) !busy |-> cnt == 2'd0)
    else $error("chunk count not cleared");
  a_rem: assert property (@(posedge clk) disable iff (rst) done |-> r < den)
    else $error("remainder not reduced");
  a_done: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("done while busy");
`endif

endmodule

### hdl/totp_hmac_sha1_base26_code.sv
// Channel  | Signals                             | Dir | Request moves
// ---------+-------------------------------------+-----+-----------------------
// in       | in_valid, in_stall, unix_time       | in  | one Unix time
// out      | out_valid, out_stall, code_char_0-4 | out | five code characters
// cfg      | cfg_valid, cfg_ready, cfg_index,    | in  | one 64-bit key word
//          | cfg_data                            |     |
//
// A request runs, from its accepting edge to out_valid, through the divide
// by 30 (four 16-bit chunk steps on the shared reciprocal divider), four
// 80-round passes of one shared SHA-1 round unit, truncation, the five
// base-26 digits on the same divider, and the load of the output register.
// The next request is taken only after the sequencer is back in S_IDLE.
// Reset (rst, synchronous) returns the sequencer to S_IDLE, empties the output
// register and clears the key to zero.
// in_stall is high whenever a request is in work; a finished result waits in
// the output register while out_stall is high, and the following request may
// finish and wait behind it in S_OUT, keeping in_stall high until it moves on.
module totp_hmac_sha1_base26_code (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] unix_time,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [6:0]  code_char_0,
  output logic [6:0]  code_char_1,
  output logic [6:0]  code_char_2,
  output logic [6:0]  code_char_3,
  output logic [6:0]  code_char_4,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [totp_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [63:0] cfg_data
);
  import totp_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_DIV   = 10'b0000000010,
    S_DWAIT = 10'b0000000100,
    S_SHA   = 10'b0000001000,
    S_SWAIT = 10'b0000010000,
    S_TRUNC = 10'b0000100000,
    S_DIG   = 10'b0001000000,
    S_GWAIT = 10'b0010000000,
    S_OUT   = 10'b0100000000,
    S_SPARE = 10'b1000000000
  } state_t;

  state_t      state;
  logic [63:0] key [KeyWords];
  logic [63:0] unix_time_q;
  logic [63:0] slice;
  logic [1:0]  pass;      // 0 inner key, 1 inner msg, 2 outer key, 3 outer msg
  logic [2:0]  dig;
  logic [31:0] inner [5];
  logic [30:0] code;
  logic [6:0]  chars [CodeLen];

  // output register, frees the sequencer while a result waits
  logic        out_full;
  logic        out_load;
  logic [6:0]  res_char [CodeLen];

  sha_ctl_t    sctl;
  sha_sts_t    ssts;
  block_t      sblk;
  digest_t     sdig;

  logic        dstart, ddone, dsel;
  logic [63:0] dnum, dquo;
  logic [4:0]  drem;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < KeyWords; i++) key[i] <= '0;
    end else if (cfg_valid && cfg_ready) begin
      key[cfg_index] <= cfg_data;
    end
  end

  // message block per pass
  always_comb begin
    sblk = '0;
    case (pass)
      2'd0: for (int i = 0; i < KeyWords; i++)
              sblk[511 - 64*i -: 64] = key[i] ^ {IpadWord, IpadWord};
      2'd1: begin
        sblk[511 -: 64] = slice;
        sblk[447 -: 32] = PadOne;
        sblk[31:0]      = InnerLen;
      end
      2'd2: for (int i = 0; i < KeyWords; i++)
              sblk[511 - 64*i -: 64] = key[i] ^ {OpadWord, OpadWord};
      default: begin
        for (int i = 0; i < 5; i++) sblk[511 - 32*i -: 32] = inner[i];
        sblk[351 -: 32] = PadOne;
        sblk[31:0]      = OuterLen;
      end
    endcase
  end

  assign sctl.start = (state == S_SHA);
  assign sctl.fresh = (pass == 2'd0) || (pass == 2'd2);

  totp_sha1_core u_sha (
    .clk(clk), .rst(rst), .ctl(sctl), .blk(sblk), .sts(ssts), .digest(sdig)
  );

  assign dstart = (state == S_DIV) || (state == S_DIG);
  assign dnum   = (state == S_DIV) ? unix_time_q : {33'd0, code};
  assign dsel   = (state == S_DIG);

  totp_div_unit u_div (
    .clk(clk), .rst(rst), .start(dstart), .digit(dsel), .num(dnum),
    .done(ddone), .quo(dquo), .rem(drem)
  );

  // dynamic truncation
  logic [3:0]   off;
  logic [159:0] sh;
  assign off = sdig[3:0];
  assign sh  = sdig << {off, 3'b000};

  assign out_load = (state == S_OUT) && (!out_full || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pass  <= '0;
      dig   <= '0;
    end else begin
      case (state)
        S_IDLE: if (in_valid) begin
          unix_time_q <= unix_time;
          state <= S_DIV;
        end
        S_DIV:   state <= S_DWAIT;
        S_DWAIT: if (ddone) begin
          slice <= dquo;
          pass  <= 2'd0;
          state <= S_SHA;
        end
        S_SHA:   state <= S_SWAIT;
        S_SWAIT: if (ssts.done) begin
          if (pass == 2'd1) begin
            for (int i = 0; i < 5; i++) inner[i] <= sdig[159 - 32*i -: 32];
          end
          if (pass == 2'd3) state <= S_TRUNC;
          else begin
            pass  <= pass + 2'd1;
            state <= S_SHA;
          end
        end
        S_TRUNC: begin
          code  <= sh[158:128];
          dig   <= '0;
          state <= S_DIG;
        end
        S_DIG:   state <= S_GWAIT;
        S_GWAIT: if (ddone) begin
          chars[dig] <= alpha_char(drem);
          code <= dquo[30:0];
          if (dig == 3'd4) state <= S_OUT;
          else begin
            dig   <= dig + 3'd1;
            state <= S_DIG;
          end
        end
        S_OUT: if (out_load) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (out_load) begin
      out_full <= 1'b1;
      for (int i = 0; i < CodeLen; i++) res_char[i] <= chars[i];
    end else if (!out_stall) begin
      out_full <= 1'b0;
    end
  end

  assign in_stall    = (state != S_IDLE);
  assign out_valid   = out_full;
  assign code_char_0 = res_char[0];
  assign code_char_1 = res_char[1];
  assign code_char_2 = res_char[2];
  assign code_char_3 = res_char[3];
  assign code_char_4 = res_char[4];

`ifndef SYNTHESIS
  a_sha_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !ssts.busy) else $error("sha busy while idle");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid) else $error("result dropped");
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> $stable(code_char_0) && $stable(code_char_4))
    else $error("stalled result changed");
  a_one_req: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall) else $error("second request taken");
`endif

endmodule
